// ===== design/sfct_pkg.sv =====
`timescale 1ns / 1ps

package sfct_pkg;

  localparam int CACHE_SLOTS = 8;
  localparam int NUM_SPRITES = 32;
  localparam int MAX_FRAMES  = 8;

  localparam int SLOT_W   = $clog2(CACHE_SLOTS);
  localparam int SPR_W    = 5;
  localparam int FRAME_W  = 3;
  localparam int COUNT_W  = 4;
  localparam int INVAL_W  = 8;
  localparam int SPR_AW   = $clog2(NUM_SPRITES);
  localparam int LCG_W    = 16;

  localparam logic [LCG_W-1:0] LCG_SEED_INIT = 16'hace1;
  localparam logic [LCG_W-1:0] LCG_INC       = 16'd43;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_TEST = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  typedef struct packed {
    logic [SPR_W-1:0]   sprite;
    logic [FRAME_W-1:0] frame;
  } tag_t;

  typedef struct packed {
    logic               do_lookup;
    logic               do_load;
    logic [SPR_W-1:0]   sprite;
    logic [FRAME_W-1:0] frame;
  } tag_req_t;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic [CACHE_SLOTS-1:0] inval;
  } tag_rsp_t;

  // Frame number reduced modulo a nonzero count. A 3-bit frame needs at most
  // one subtraction on every path, so no compare-subtract chain is built.
  function automatic logic [FRAME_W-1:0] frame_mod(input logic [FRAME_W-1:0] fsel,
                                                   input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] f;
    logic [COUNT_W-1:0] r;
    f = {1'b0, fsel};
    case (cnt)
      COUNT_W'(1): r = '0;
      COUNT_W'(2): r = {3'b000, fsel[0]};
      COUNT_W'(3): begin
        if (f >= COUNT_W'(6)) begin
          r = f - COUNT_W'(6);
        end else if (f >= COUNT_W'(3)) begin
          r = f - COUNT_W'(3);
        end else begin
          r = f;
        end
      end
      COUNT_W'(4): r = {2'b00, fsel[1:0]};
      default: r = (f >= cnt) ? f - cnt : f;
    endcase
    return r[FRAME_W-1:0];
  endfunction

endpackage

// ===== design/sfct_if.sv =====
`timescale 1ns / 1ps

interface sfct_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [sfct_pkg::SPR_W-1:0]   sprite_num;
  logic [sfct_pkg::FRAME_W-1:0] frame_sel;
  logic [sfct_pkg::COUNT_W-1:0] frame_total;

  modport source (output valid, func, sprite_num, frame_sel, frame_total, input ready);
  modport sink   (input valid, func, sprite_num, frame_sel, frame_total, output ready);
endinterface

interface sfct_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [sfct_pkg::SLOT_W-1:0]  slot;
  logic [sfct_pkg::FRAME_W-1:0] frame_used;
  logic [sfct_pkg::INVAL_W-1:0] invalidated;

  modport source (output valid, status, slot, frame_used, invalidated, input ready);
  modport sink   (input valid, status, slot, frame_used, invalidated, output ready);
endinterface

// ===== design/sfct_ram.sv =====
`timescale 1ns / 1ps

module sfct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sfct_tags.sv =====
`timescale 1ns / 1ps

module sfct_tags (
  input  logic               clk,
  input  logic               rst,
  input  sfct_pkg::tag_req_t req,
  output sfct_pkg::tag_rsp_t rsp
);

  localparam int N = sfct_pkg::CACHE_SLOTS;

  sfct_pkg::tag_t                   tags [N];
  logic [N-1:0]                     valid;
  logic [sfct_pkg::LCG_W-1:0]       seed;
  logic [sfct_pkg::LCG_W-1:0]       seed_next;
  logic [N-1:0]                     hit_vec;
  logic [N-1:0]                     spr_vec;
  logic [sfct_pkg::SLOT_W-1:0]      hit_slot;
  logic [sfct_pkg::SLOT_W-1:0]      free_slot;
  logic                             any_free;
  logic [sfct_pkg::SLOT_W-1:0]      victim;

  // Per-slot compare lanes.
  always_comb begin
    for (int s = 0; s < N; s++) begin
      spr_vec[s] = valid[s] && (tags[s].sprite == req.sprite);
      hit_vec[s] = spr_vec[s] && (tags[s].frame == req.frame);
    end
  end

  // Lowest hit and lowest free slot.
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    any_free  = 1'b0;
    for (int s = N - 1; s >= 0; s--) begin
      if (hit_vec[s]) begin
        hit_slot = sfct_pkg::SLOT_W'(s);
      end
      if (!valid[s]) begin
        free_slot = sfct_pkg::SLOT_W'(s);
        any_free  = 1'b1;
      end
    end
  end

  // seed * 17 + 43, modulo 2^16.
  assign seed_next = (seed << 4) + seed + sfct_pkg::LCG_INC;
  assign victim    = any_free ? free_slot : seed_next[8 +: sfct_pkg::SLOT_W];

  assign rsp.hit   = |hit_vec;
  assign rsp.slot  = (|hit_vec) ? hit_slot : victim;
  assign rsp.inval = spr_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      seed  <= sfct_pkg::LCG_SEED_INIT;
    end else if (req.do_load) begin
      valid <= valid & ~spr_vec;
    end else if (req.do_lookup && !(|hit_vec)) begin
      valid[victim] <= 1'b1;
      if (!any_free) begin
        seed <= seed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.do_lookup && !(|hit_vec)) begin
      tags[victim].sprite <= req.sprite;
      tags[victim].frame  <= req.frame;
    end
  end

endmodule

// ===== design/sprite_frame_cache_tags.sv =====
`timescale 1ns / 1ps

// Tag controller for an eight-slot, fully associative sprite frame cache.
// Channel "lookup" carries transactions: func selects a frame lookup or a
// sprite load (frame_total is the new frame count; zero marks the sprite
// absent). Channel "result" returns exactly one transaction per input:
// status hit, miss (fill needed, slot is the slot that was claimed), test
// pattern fallback, or load done with one invalidated bit per slot.
// Each transaction is first accepted and the sprite's frame count read from
// the count RAM (registered read); then it is evaluated: the frame reduced,
// all tags compared, a victim picked and tags and count written back. A new
// transaction is accepted only in the idle state, so none is taken before the
// current one has been evaluated and its result registered.
// The result sits in an output register; while it is not taken the block
// holds the next transaction in its evaluate cycle and accepts nothing.
// Reset: all slots invalid, all frame counts zero (valid bits on the count
// RAM, no clearing pass), LCG seed 0xace1; ready stays low while reset is
// high and rises in the first cycle after reset falls.

module sprite_frame_cache_tags (
  input  logic        clk,
  input  logic        rst,
  sfct_in_if.sink     lookup,
  sfct_out_if.source  result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                             state;
  logic                             state_next;
  logic                             func_q;
  logic [sfct_pkg::SPR_W-1:0]       spr_q;
  logic [sfct_pkg::FRAME_W-1:0]     fsel_q;
  logic [sfct_pkg::COUNT_W-1:0]     ftot_q;
  logic [sfct_pkg::NUM_SPRITES-1:0] cnt_vld;
  logic [sfct_pkg::COUNT_W-1:0]     ram_rdata;
  logic [sfct_pkg::COUNT_W-1:0]     count;
  logic [sfct_pkg::COUNT_W-1:0]     ftot_sat;
  logic [sfct_pkg::FRAME_W-1:0]     used;
  logic                             spr_ok;
  logic                             accept;
  logic                             go;
  logic                             ram_we;
  sfct_pkg::tag_req_t               treq;
  sfct_pkg::tag_rsp_t               trsp;

  logic                             out_valid;
  logic [1:0]                       out_status;
  logic [sfct_pkg::SLOT_W-1:0]      out_slot;
  logic [sfct_pkg::FRAME_W-1:0]     out_used;
  logic [sfct_pkg::INVAL_W-1:0]     out_inval;

  assign lookup.ready = (state == ST_IDLE) && !rst;
  assign accept       = lookup.valid && lookup.ready;
  // Evaluate once the output register is free or being drained.
  assign go           = (state == ST_EXEC) && (!out_valid || result.ready);

  assign spr_ok   = ({1'b0, spr_q} < (sfct_pkg::SPR_W + 1)'(sfct_pkg::NUM_SPRITES));
  assign count    = (spr_ok && cnt_vld[spr_q[sfct_pkg::SPR_AW-1:0]]) ? ram_rdata : '0;
  assign used     = sfct_pkg::frame_mod(fsel_q, count);
  assign ftot_sat = (ftot_q > sfct_pkg::COUNT_W'(sfct_pkg::MAX_FRAMES))
                    ? sfct_pkg::COUNT_W'(sfct_pkg::MAX_FRAMES) : ftot_q;
  assign ram_we   = go && (func_q == sfct_pkg::FUNC_LOAD) && spr_ok;

  sfct_ram #(
    .WIDTH (sfct_pkg::COUNT_W),
    .DEPTH (sfct_pkg::NUM_SPRITES)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (spr_q[sfct_pkg::SPR_AW-1:0]),
    .wdata (ftot_sat),
    .re    (accept),
    .raddr (lookup.sprite_num[sfct_pkg::SPR_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    treq.do_lookup = go && (func_q == sfct_pkg::FUNC_LOOKUP) && (count != '0);
    treq.do_load   = go && (func_q == sfct_pkg::FUNC_LOAD);
    treq.sprite    = spr_q;
    treq.frame     = used;
  end

  sfct_tags u_tags (
    .clk (clk),
    .rst (rst),
    .req (treq),
    .rsp (trsp)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt_vld   <= '0;
    end else begin
      state <= state_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        cnt_vld[spr_q[sfct_pkg::SPR_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Capture the transaction; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= lookup.func;
      spr_q  <= lookup.sprite_num;
      fsel_q <= lookup.frame_sel;
      ftot_q <= lookup.frame_total;
    end
  end

  // Build the result.
  always_ff @(posedge clk) begin
    if (go) begin
      out_status <= sfct_pkg::ST_TEST;
      out_slot   <= '0;
      out_used   <= '0;
      out_inval  <= '0;
      if (func_q == sfct_pkg::FUNC_LOAD) begin
        out_status <= sfct_pkg::ST_LOAD;
        out_inval  <= sfct_pkg::INVAL_W'(trsp.inval);
      end else if (count != '0) begin
        out_status <= trsp.hit ? sfct_pkg::ST_HIT : sfct_pkg::ST_MISS;
        out_slot   <= trsp.slot;
        out_used   <= used;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.slot        = out_slot;
  assign result.frame_used  = out_used;
  assign result.invalidated = out_inval;

endmodule
